// ----- design/ucer_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ucer_pkg
// Shared types, codes and descriptor tables of the control endpoint responder.
// ----------------------------------------------------------------------------
package ucer_pkg;

  localparam int unsigned MaxPacket  = 64;
  localparam int unsigned RomDepth   = 128;
  localparam int unsigned QueueDepth = 2;
  localparam int unsigned RomLen     = 83;
  localparam int unsigned DevLen     = 18;
  localparam int unsigned LangLen    = 4;

  localparam logic [7:0] RomCfg      = 8'd0;
  localparam logic [7:0] RomHidClass = 8'd18;
  localparam logic [7:0] RomReport   = 8'd41;
  localparam logic [7:0] RomText     = 8'd70;

  localparam logic [7:0] LenDevice   = 8'd18;
  localparam logic [7:0] LenCfg      = 8'd41;
  localparam logic [7:0] LenLang     = 8'd4;
  localparam logic [7:0] LenShort    = 8'd18;
  localparam logic [7:0] LenLong     = 8'd28;
  localparam logic [7:0] LenReport   = 8'd29;
  localparam logic [7:0] LenHidClass = 8'd9;
  localparam logic [7:0] LenStatus   = 8'd2;
  localparam logic [7:0] LenConfig   = 8'd1;
  localparam logic [7:0] CharsShort  = 8'd8;
  localparam logic [7:0] CharsLong   = 8'd13;
  localparam logic [7:0] StrHeadType = 8'd3;

  localparam logic [7:0] ReqGetStatus     = 8'h00;
  localparam logic [7:0] ReqSetAddress    = 8'h05;
  localparam logic [7:0] ReqGetDescriptor = 8'h06;
  localparam logic [7:0] ReqGetConfig     = 8'h08;
  localparam logic [7:0] ReqSetConfig     = 8'h09;
  localparam logic [7:0] ReqSetIdle       = 8'h0A;
  localparam logic [7:0] ReqSetProtocol   = 8'h0B;

  localparam logic [7:0] DescDevice   = 8'h01;
  localparam logic [7:0] DescConfig   = 8'h02;
  localparam logic [7:0] DescString   = 8'h03;
  localparam logic [7:0] DescHidClass = 8'h21;
  localparam logic [7:0] DescReport   = 8'h22;

  localparam logic [1:0] TypeStandard = 2'd0;
  localparam logic [1:0] TypeClass    = 2'd1;
  localparam logic [4:0] RecipDevice  = 5'd0;

  localparam logic CfgVendorId  = 1'b0;
  localparam logic CfgProductId = 1'b1;

  typedef enum logic [1:0] {
    EvBusReset = 2'd0,
    EvSetup    = 2'd1,
    EvInDone   = 2'd2,
    EvOutDone  = 2'd3
  } event_e;

  typedef enum logic [1:0] {
    KindRearm = 2'd0,
    KindData  = 2'd1,
    KindZlp   = 2'd2,
    KindStall = 2'd3
  } reply_kind_e;

  typedef enum logic [2:0] {
    SrcNone   = 3'd0,
    SrcDevice = 3'd1,
    SrcRom    = 3'd2,
    SrcLang   = 3'd3,
    SrcShort  = 3'd4,
    SrcLong   = 3'd5,
    SrcStatus = 3'd6,
    SrcConfig = 3'd7
  } reply_src_e;

  typedef struct packed {
    logic [1:0]  opcode;
    logic [7:0]  request_type;
    logic [7:0]  request_code;
    logic [15:0] value_field;
    logic [15:0] length_field;
  } ev_req_t;

  typedef struct packed {
    logic [1:0] reply_kind;
    logic [7:0] data_byte;
    logic [6:0] packet_bytes;
    logic       last_of_run;
    logic [6:0] device_address;
    logic       is_configured;
  } ev_rsp_t;

  typedef struct packed {
    reply_kind_e kind;
    reply_src_e  src;
    logic [7:0]  offset;
    logic [6:0]  count;
    logic [6:0]  address;
    logic        configured;
  } job_t;

  localparam logic [0:RomLen-1][7:0] RomImage = {
    8'h09, 8'h02, 8'h29, 8'h00, 8'h01, 8'h01, 8'h00, 8'h80, 8'h32,
    8'h09, 8'h04, 8'h00, 8'h00, 8'h02, 8'h03, 8'h00, 8'h00, 8'h00,
    8'h09, 8'h21, 8'h11, 8'h01, 8'h00, 8'h01, 8'h22, 8'h1D, 8'h00,
    8'h07, 8'h05, 8'h81, 8'h03, 8'h40, 8'h00, 8'h01,
    8'h07, 8'h05, 8'h01, 8'h03, 8'h40, 8'h00, 8'h01,
    8'h06, 8'h00, 8'hFF, 8'h09, 8'h01, 8'hA1, 8'h01, 8'h85, 8'h04, 8'h09, 8'h02, 8'h15, 8'h00,
    8'h26, 8'hFF, 8'h00, 8'h75, 8'h08, 8'h95, 8'h3F, 8'h91, 8'h02, 8'h09, 8'h02, 8'h95, 8'h3F,
    8'h81, 8'h02, 8'hC0,
    8'h4C, 8'h6F, 8'h67, 8'h69, 8'h63, 8'h50, 8'h61, 8'h64, 8'h20, 8'h42, 8'h6F, 8'h6F, 8'h74
  };

  localparam logic [0:DevLen-1][7:0] DevImage = {
    8'd18, 8'h01, 8'h00, 8'h02, 8'h00, 8'h00, 8'h00, 8'h40, 8'h00,
    8'h00, 8'h00, 8'h00, 8'h00, 8'h01, 8'h01, 8'h02, 8'h00, 8'h01
  };

  localparam logic [0:LangLen-1][7:0] LangImage = {8'h04, 8'h03, 8'h09, 8'h04};

  function automatic logic [7:0] rom_byte(input logic [7:0] addr);
    rom_byte = 8'h00;
    if (addr < 8'(RomLen)) begin
      rom_byte = RomImage[addr[6:0]];
    end
  endfunction

  function automatic logic [7:0] dev_byte(input logic [7:0] addr);
    dev_byte = 8'h00;
    if (addr < 8'(DevLen)) begin
      dev_byte = DevImage[addr[4:0]];
    end
  endfunction

  function automatic logic [7:0] lang_byte(input logic [7:0] addr);
    lang_byte = 8'h00;
    if (addr < 8'(LangLen)) begin
      lang_byte = LangImage[addr[1:0]];
    end
  endfunction

endpackage
`default_nettype wire

// ----- design/ucer_front.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ucer_front
// Decodes bus events and setup requests, tracks address, configuration and
// reply progress, and issues one packet job per accepted request.
// ----------------------------------------------------------------------------
module ucer_front import ucer_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    req_valid_i,
  output logic    req_ready_o,
  input  ev_req_t req_i,
  output logic    job_valid_o,
  input  logic    job_ready_i,
  output job_t    job_o
);

  reply_src_e src_q, src_d;
  logic [7:0] off_q, off_d;
  logic [7:0] rem_q, rem_d;
  logic [6:0] pend_addr_q, pend_addr_d;
  logic       pend_q, pend_d;
  logic [6:0] addr_q, addr_d;
  logic       cfg_q, cfg_d;

  logic       push;
  logic [4:0] recip;
  logic [1:0] rtype;
  logic [7:0] lo;
  logic [7:0] dtype;
  logic       is_std;
  logic       desc_ok;
  reply_src_e desc_src;
  logic [7:0] desc_off;
  logic [7:0] desc_len;
  logic       start;
  reply_src_e s_src;
  logic [7:0] s_off;
  logic [7:0] s_len;
  logic       chunk;
  logic       stall;
  logic [7:0] n;

  assign req_ready_o = job_ready_i;
  assign job_valid_o = req_valid_i;
  assign push        = req_valid_i && job_ready_i;

  assign recip  = req_i.request_type[4:0];
  assign rtype  = req_i.request_type[6:5];
  assign lo     = req_i.value_field[7:0];
  assign dtype  = req_i.value_field[15:8];
  assign is_std = (rtype == TypeStandard);

  always_comb begin
    desc_ok  = 1'b1;
    desc_src = SrcNone;
    desc_off = 8'd0;
    desc_len = 8'd0;
    unique case (dtype)
      DescDevice: begin
        desc_src = SrcDevice;
        desc_len = LenDevice;
      end
      DescConfig: begin
        desc_src = SrcRom;
        desc_off = RomCfg;
        desc_len = LenCfg;
      end
      DescString: begin
        if (lo == 8'd0) begin
          desc_src = SrcLang;
          desc_len = LenLang;
        end else if (lo == 8'd1) begin
          desc_src = SrcShort;
          desc_len = LenShort;
        end else begin
          desc_src = SrcLong;
          desc_len = LenLong;
        end
      end
      DescReport: begin
        desc_src = SrcRom;
        desc_off = RomReport;
        desc_len = LenReport;
      end
      DescHidClass: begin
        desc_src = SrcRom;
        desc_off = RomHidClass;
        desc_len = LenHidClass;
      end
      default: desc_ok = 1'b0;
    endcase
  end

  always_comb begin
    src_d       = src_q;
    off_d       = off_q;
    rem_d       = rem_q;
    pend_addr_d = pend_addr_q;
    pend_d      = pend_q;
    addr_d      = addr_q;
    cfg_d       = cfg_q;
    start       = 1'b0;
    s_src       = SrcNone;
    s_off       = 8'd0;
    s_len       = 8'd0;
    chunk       = 1'b0;
    stall       = 1'b0;
    n           = 8'd0;
    job_o       = '0;

    unique case (event_e'(req_i.opcode))
      EvBusReset: begin
        src_d       = SrcNone;
        off_d       = 8'd0;
        rem_d       = 8'd0;
        pend_addr_d = 7'd0;
        pend_d      = 1'b0;
        addr_d      = 7'd0;
        cfg_d       = 1'b0;
      end
      EvSetup: begin
        src_d  = SrcNone;
        off_d  = 8'd0;
        rem_d  = 8'd0;
        pend_d = 1'b0;
        if (is_std && req_i.request_code == ReqSetAddress && recip == RecipDevice) begin
          pend_addr_d = lo[6:0];
          pend_d      = 1'b1;
          chunk       = 1'b1;
        end else if (is_std && req_i.request_code == ReqSetConfig
                     && recip == RecipDevice) begin
          cfg_d = (lo != 8'd0);
          chunk = 1'b1;
        end else if (is_std && req_i.request_code == ReqGetDescriptor && desc_ok) begin
          start = 1'b1;
          s_src = desc_src;
          s_off = desc_off;
          s_len = desc_len;
        end else if (is_std && req_i.request_code == ReqGetStatus
                     && recip == RecipDevice) begin
          start = 1'b1;
          s_src = SrcStatus;
          s_len = LenStatus;
        end else if (is_std && req_i.request_code == ReqGetConfig) begin
          start = 1'b1;
          s_src = SrcConfig;
          s_len = LenConfig;
        end else if (rtype == TypeClass && (req_i.request_code == ReqSetIdle
                     || req_i.request_code == ReqSetProtocol)) begin
          chunk = 1'b1;
        end else begin
          stall = 1'b1;
        end
      end
      EvInDone: begin
        if (pend_q) begin
          addr_d = pend_addr_q;
          pend_d = 1'b0;
        end
        chunk = (rem_q != 8'd0);
      end
      EvOutDone: begin
      end
      default: begin
      end
    endcase

    if (start) begin
      chunk = 1'b1;
      src_d = s_src;
      off_d = s_off;
      rem_d = (req_i.length_field < {8'd0, s_len}) ? req_i.length_field[7:0] : s_len;
    end

    job_o.kind       = stall ? KindStall : KindRearm;
    job_o.src        = src_d;
    job_o.offset     = off_d;
    if (chunk) begin
      n          = (rem_d > 8'(MaxPacket)) ? 8'(MaxPacket) : rem_d;
      job_o.kind = (n == 8'd0) ? KindZlp : KindData;
      job_o.count = n[6:0];
      rem_d      = rem_d - n;
      off_d      = off_d + n;
    end
    job_o.address    = addr_d;
    job_o.configured = cfg_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      src_q       <= SrcNone;
      off_q       <= 8'd0;
      rem_q       <= 8'd0;
      pend_addr_q <= 7'd0;
      pend_q      <= 1'b0;
      addr_q      <= 7'd0;
      cfg_q       <= 1'b0;
    end else if (push) begin
      src_q       <= src_d;
      off_q       <= off_d;
      rem_q       <= rem_d;
      pend_addr_q <= pend_addr_d;
      pend_q      <= pend_d;
      addr_q      <= addr_d;
      cfg_q       <= cfg_d;
    end
  end

endmodule
`default_nettype wire

// ----- design/ucer_fifo.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ucer_fifo
// Short job queue between the request decoder and the packet sender.
// ----------------------------------------------------------------------------
module ucer_fifo import ucer_pkg::*; #(
  parameter int unsigned Depth = QueueDepth
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic wr_valid_i,
  output logic wr_ready_o,
  input  job_t wr_data_i,
  output logic rd_valid_o,
  input  logic rd_ready_i,
  output job_t rd_data_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  job_t            mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            push;
  logic            pop;

  assign wr_ready_o = (cnt_q != CntW'(Depth));
  assign rd_valid_o = (cnt_q != '0);
  assign rd_data_o  = mem_q[rd_ptr_q];
  assign push       = wr_valid_i && wr_ready_o;
  assign pop        = rd_valid_o && rd_ready_i;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    if (push) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    cnt_d = cnt_q + CntW'(push) - CntW'(pop);
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= wr_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

endmodule
`default_nettype wire

// ----- design/ucer_back.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ucer_back
// Expands packet jobs into reply items, one byte per cycle while the output
// accepts, from the descriptor sources, into a registered output stage.
// ----------------------------------------------------------------------------
module ucer_back import ucer_pkg::*; #(
  parameter int unsigned RomDepth = ucer_pkg::RomDepth
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        job_valid_i,
  output logic        job_ready_o,
  input  job_t        job_i,
  input  logic [15:0] vendor_i,
  input  logic [15:0] product_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output ev_rsp_t     out_o
);

  localparam int unsigned IdxW = $clog2(RomDepth);

  logic [7:0] rom_mem [RomDepth];

  logic       busy_q, busy_d;
  job_t       job_q;
  logic [6:0] left_q, left_d;
  logic [7:0] off_q, off_d;
  logic       out_valid_q, out_valid_d;
  ev_rsp_t    out_q;
  ev_rsp_t    item;
  logic       load;
  logic       slot_free;
  logic       emit;
  logic [7:0] p;
  logic [6:0] chr;
  logic [7:0] rom_addr;
  logic [7:0] rom_rd;
  logic [7:0] str_short;
  logic [7:0] str_long;
  logic [7:0] fetch;

  for (genvar i = 0; i < RomDepth; i++) begin : g_rom
    assign rom_mem[i] = rom_byte(8'(i));
  end

  assign job_ready_o = !busy_q;
  assign load        = job_valid_i && !busy_q;
  assign slot_free   = !out_valid_q || out_ready_i;
  assign emit        = busy_q && slot_free;
  assign out_valid_o = out_valid_q;
  assign out_o       = out_q;

  assign p        = off_q;
  assign chr      = 7'((p - 8'd2) >> 1);
  assign rom_addr = (job_q.src == SrcRom) ? p : RomText + {1'b0, chr};
  assign rom_rd   = ({1'b0, rom_addr} < 9'(RomDepth)) ? rom_mem[rom_addr[IdxW-1:0]] : 8'h00;

  always_comb begin
    str_short = 8'h00;
    str_long  = 8'h00;
    if (p == 8'd0) begin
      str_short = 8'd2 + (CharsShort << 1);
      str_long  = 8'd2 + (CharsLong << 1);
    end else if (p == 8'd1) begin
      str_short = StrHeadType;
      str_long  = StrHeadType;
    end else if (!p[0]) begin
      str_short = ({1'b0, chr} < CharsShort) ? rom_rd : 8'h00;
      str_long  = ({1'b0, chr} < CharsLong) ? rom_rd : 8'h00;
    end
  end

  always_comb begin
    fetch = 8'h00;
    unique case (job_q.src)
      SrcDevice: begin
        case (p)
          8'd7:    fetch = 8'(MaxPacket);
          8'd8:    fetch = vendor_i[7:0];
          8'd9:    fetch = vendor_i[15:8];
          8'd10:   fetch = product_i[7:0];
          8'd11:   fetch = product_i[15:8];
          default: fetch = dev_byte(p);
        endcase
      end
      SrcRom:    fetch = rom_rd;
      SrcLang:   fetch = lang_byte(p);
      SrcShort:  fetch = str_short;
      SrcLong:   fetch = str_long;
      SrcConfig: fetch = (p == 8'd0) ? {7'd0, job_q.configured} : 8'h00;
      default:   fetch = 8'h00;
    endcase
  end

  always_comb begin
    item                = '0;
    item.reply_kind     = job_q.kind;
    item.last_of_run    = (left_q == 7'd1);
    item.device_address = job_q.address;
    item.is_configured  = job_q.configured;
    if (job_q.kind == KindData) begin
      item.data_byte    = fetch;
      item.packet_bytes = job_q.count;
    end
  end

  always_comb begin
    busy_d      = busy_q;
    left_d      = left_q;
    off_d       = off_q;
    out_valid_d = out_valid_q && !out_ready_i;
    if (load) begin
      busy_d = 1'b1;
      left_d = (job_i.kind == KindData) ? job_i.count : 7'd1;
      off_d  = job_i.offset;
    end else if (emit) begin
      out_valid_d = 1'b1;
      left_d      = left_q - 7'd1;
      off_d       = off_q + 8'd1;
      busy_d      = (left_q != 7'd1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      job_q <= job_i;
    end
    if (emit) begin
      out_q <= item;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q      <= 1'b0;
      left_q      <= 7'd0;
      off_q       <= 8'd0;
      out_valid_q <= 1'b0;
    end else begin
      busy_q      <= busy_d;
      left_q      <= left_d;
      off_q       <= off_d;
      out_valid_q <= out_valid_d;
    end
  end

  a_busy_has_items : assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q |-> (left_q != 7'd0))
    else $error("busy with no items left");

  a_non_last_keeps_busy : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !out_q.last_of_run) |-> busy_q)
    else $error("run ended without a last item");

  a_single_item_is_last : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_q.reply_kind != KindData) |-> out_q.last_of_run)
    else $error("non-data reply not marked last");

  a_packet_size : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_q.reply_kind == KindData)
      |-> (out_q.packet_bytes != 7'd0 && out_q.packet_bytes <= 7'(MaxPacket)))
    else $error("data packet size out of range");

  a_emit_after_load : assert property (@(posedge clk_i) disable iff (!rst_ni)
    load |=> (busy_q && !job_ready_o))
    else $error("job taken but sender idle");

endmodule
`default_nettype wire

// ----- design/usb_control_endpoint_responder.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// usb_control_endpoint_responder
// Endpoint-0 responder for a HID device: decodes bus events and standard or
// HID class requests, answers with status, stall or descriptor data packets.
//
//   Channel  Direction  Handshake            Payload
//   cfg      in         cfg_we_i             cfg_idx_i, cfg_wdata_i (16 bits)
//   in       in         in_valid_i/ready_o   in_req_i  (ev_req_t)
//   out      out        out_valid_o/ready_i  out_rsp_o (ev_rsp_t)
//
// A request is decoded in the cycle it is accepted and queued as one job.
// The sender emits one item per cycle while the output is not stalled: 1 item
// for a status, stall or re-arm reply, n items for a data packet of n bytes
// (n up to 64), and it picks up each job before its first item. Output stalls
// hold the sender; the queue keeps taking requests until full. Reset is
// asynchronous and needs no clearing pass.
module usb_control_endpoint_responder import ucer_pkg::*; #(
  parameter int unsigned RomDepth   = ucer_pkg::RomDepth,
  parameter int unsigned QueueDepth = ucer_pkg::QueueDepth
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic        cfg_idx_i,
  input  logic [15:0] cfg_wdata_i,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  ev_req_t     in_req_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output ev_rsp_t     out_rsp_o
);

  logic [15:0] vendor_q, vendor_d;
  logic [15:0] product_q, product_d;

  logic job_wr_valid;
  logic job_wr_ready;
  job_t job_wr;
  logic job_rd_valid;
  logic job_rd_ready;
  job_t job_rd;

  always_comb begin
    vendor_d  = vendor_q;
    product_d = product_q;
    if (cfg_we_i) begin
      case (cfg_idx_i)
        CfgVendorId:  vendor_d  = cfg_wdata_i;
        CfgProductId: product_d = cfg_wdata_i;
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vendor_q  <= 16'd0;
      product_q <= 16'd0;
    end else begin
      vendor_q  <= vendor_d;
      product_q <= product_d;
    end
  end

  ucer_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (in_valid_i),
    .req_ready_o (in_ready_o),
    .req_i       (in_req_i),
    .job_valid_o (job_wr_valid),
    .job_ready_i (job_wr_ready),
    .job_o       (job_wr)
  );

  ucer_fifo #(
    .Depth (QueueDepth)
  ) u_fifo (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .wr_valid_i (job_wr_valid),
    .wr_ready_o (job_wr_ready),
    .wr_data_i  (job_wr),
    .rd_valid_o (job_rd_valid),
    .rd_ready_i (job_rd_ready),
    .rd_data_o  (job_rd)
  );

  ucer_back #(
    .RomDepth (RomDepth)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .job_valid_i (job_rd_valid),
    .job_ready_o (job_rd_ready),
    .job_i       (job_rd),
    .vendor_i    (vendor_q),
    .product_i   (product_q),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_o       (out_rsp_o)
  );

endmodule
`default_nettype wire
